>>> sv/modular_exponentiation_assert.svh
// Assertion macros for the modular exponentiation block.
// Used by modexp_mulmod and modular_exponentiation; expects clk and rst_n in scope.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef SYNTHESIS
`define ME_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("modexp assertion failed");
`define ME_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("modexp assertion failed");
`else
`define ME_ASSERT(label, prop)
`define ME_ASSERT_NEXT(label, cond, prop)
`endif
`endif

>>> sv/modexp_pkg.sv
// Shared widths and interface structs for the modular exponentiation block.
// No dependencies.
package modexp_pkg;

    localparam int FIELD_WIDTH = 32;               // port field width
    localparam int MOD_WIDTH   = 32;               // modulus bits in use (8..32)
    localparam int EXP_WIDTH   = 32;               // exponent bits in use (1..32)
    localparam int ACC_WIDTH   = MOD_WIDTH + 2;    // 2r + b < 3m
    localparam int CNT_WIDTH   = $clog2(FIELD_WIDTH);

    // Request to the bit-serial multiplier: product = a * b mod m, b <= m.
    typedef struct packed {
        logic                   start;
        logic [FIELD_WIDTH-1:0] a;
        logic [MOD_WIDTH-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

>>> sv/modular_exponentiation.sv
// Modular exponentiation block: top level, sequencer and register file.
// Depends on modexp_pkg, modexp_mulmod and modular_exponentiation_assert.svh.
//
// Computes base_value ** exponent mod modulus by right-to-left square and
// multiply. One item is worked on at a time; the result sits in an output
// register, so the next item may be accepted while it waits to be taken.
// All arithmetic runs through a single bit-serial modular multiplier that
// consumes one operand bit per cycle. Each item runs as the base
// reduction, then per exponent bit up to the highest set one a squaring
// and, for a one bit, a multiply. A zero exponent returns 1 unreduced.
// A modulus of zero (not allowed) behaves as 2**32, i.e. results wrap.
// Modulus resets to 1; write it only while the block is idle. cfg_ready
// is always high.
`include "modular_exponentiation_assert.svh"
module modular_exponentiation (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] modulus,
    // input items
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] base_value,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] exponent,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [modexp_pkg::FIELD_WIDTH-1:0] power_result
);
    import modexp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for an item
    localparam logic [2:0] ST_REDUCE = 3'd1;  // base mod m
    localparam logic [2:0] ST_STEP   = 3'd2;  // look at next exponent bit
    localparam logic [2:0] ST_MUL    = 3'd3;  // acc = acc * sq
    localparam logic [2:0] ST_SQR    = 3'd4;  // sq = sq * sq
    localparam logic [2:0] ST_FINISH = 3'd5;  // hand result to output reg

    logic [2:0]             state_reg, state_next;
    logic [FIELD_WIDTH-1:0] modulus_reg, modulus_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_WIDTH-1:0] result_reg, result_next;
    logic [EXP_WIDTH-1:0]   exp_reg, exp_next;
    logic [MOD_WIDTH-1:0]   acc_reg, acc_next;
    logic [MOD_WIDTH-1:0]   sq_reg, sq_next;

    logic [MOD_WIDTH-1:0] mod_low;
    logic [MOD_WIDTH:0]   mod_eff;
    mul_req_t             mul_req;
    mul_status_t          mul_stat;
    logic [MOD_WIDTH-1:0] mul_product;
    logic                 in_fire;
    logic                 out_free;

    // zero modulus acts as 2**MOD_WIDTH so every product simply wraps
    assign mod_low = modulus_reg[MOD_WIDTH-1:0];
    assign mod_eff = (mod_low == '0) ? {1'b1, {MOD_WIDTH{1'b0}}} : {1'b0, mod_low};

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;
    assign out_free     = !out_valid_reg || out_ready;

    assign modulus_next = cfg_valid ? modulus : modulus_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        mul_req.start  = 1'b0;
        mul_req.a      = FIELD_WIDTH'(sq_reg);
        mul_req.b      = sq_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // base * 1 mod m reduces the base; b = 1 <= m always
                    mul_req.start = 1'b1;
                    mul_req.a     = base_value;
                    mul_req.b     = MOD_WIDTH'(1);
                    exp_next      = exponent[EXP_WIDTH-1:0];
                    acc_next      = MOD_WIDTH'(1);
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mul_stat.done)
                begin
                    sq_next    = mul_product;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (exp_reg == '0)
                    state_next = ST_FINISH;
                else if (exp_reg[0])
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = FIELD_WIDTH'(acc_reg);
                    state_next    = ST_MUL;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    state_next    = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    acc_next      = mul_product;
                    mul_req.start = 1'b1;
                    state_next    = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mul_stat.done)
                begin
                    sq_next    = mul_product;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_next    = FIELD_WIDTH'(acc_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= FIELD_WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    modexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .mod_eff (mod_eff),
        .status  (mul_stat),
        .product (mul_product)
    );

    `ME_ASSERT(a_start_when_free, !(mul_req.start && mul_stat.busy))
    `ME_ASSERT(a_idle_mul_quiet, (state_reg != ST_IDLE) || !mul_stat.busy)
    `ME_ASSERT(a_finish_exp_done, (state_reg != ST_FINISH) || (exp_reg == '0))
    `ME_ASSERT_NEXT(a_accept_reduces, in_fire, state_reg == ST_REDUCE)

endmodule

>>> sv/modexp_mulmod.sv
// Bit-serial interleaved modular multiplier: one bit of a per cycle, MSB first.
// Depends on modexp_pkg and modular_exponentiation_assert.svh.
`include "modular_exponentiation_assert.svh"
module modexp_mulmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  modexp_pkg::mul_req_t          req,
    input  logic [modexp_pkg::MOD_WIDTH:0] mod_eff,
    output modexp_pkg::mul_status_t       status,
    output logic [modexp_pkg::MOD_WIDTH-1:0] product
);
    import modexp_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [FIELD_WIDTH-1:0] a_reg, a_next;
    logic [MOD_WIDTH-1:0]   b_reg, b_next;
    logic [MOD_WIDTH-1:0]   r_reg, r_next;

    logic [ACC_WIDTH-1:0] t;
    logic [ACC_WIDTH-1:0] m1;
    logic [ACC_WIDTH-1:0] m2;
    logic [MOD_WIDTH-1:0] r_step;

    // t = 2r + a_bit*b, then bring below m with at most one of two subtractions
    always_comb
    begin
        m1 = ACC_WIDTH'(mod_eff);
        m2 = m1 << 1;
        t  = (ACC_WIDTH'(r_reg) << 1)
           + (a_reg[FIELD_WIDTH-1] ? ACC_WIDTH'(b_reg) : '0);
        if (t >= m2)
            r_step = MOD_WIDTH'(t - m2);
        else if (t >= m1)
            r_step = MOD_WIDTH'(t - m1);
        else
            r_step = MOD_WIDTH'(t);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(FIELD_WIDTH - 1);
            a_next    = req.a;
            b_next    = req.b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next = r_step;
            a_next = a_reg << 1;
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = r_reg;

    `ME_ASSERT(a_done_not_busy, !(done_reg && busy_reg))
    `ME_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)
    `ME_ASSERT_NEXT(a_last_bit_done, busy_reg && (cnt_reg == '0) && !req.start, done_reg)

endmodule
